// ----- design/sfd_pkg.sv -----
// Package for the stuffed frame deframer: register map, reset values,
// frame position codes and the shared struct types.
// No dependencies.
package sfd_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MY_ADDRESS = 3'd0;
  localparam logic [2:0] REG_BCAST_ADDR = 3'd1;
  localparam logic [2:0] REG_TOKEN_MARK = 3'd2;
  localparam logic [2:0] REG_TOKEN_SIZE = 3'd3;
  localparam logic [2:0] REG_START_CODE = 3'd4;
  localparam logic [2:0] REG_END_CODE   = 3'd5;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int ADDR_W  = 5;   // station address width
  localparam int POS_W   = 9;

  localparam int BUFFER_BYTES_DEF = 256;

  // Reset values
  localparam logic [ADDR_W-1:0] MY_ADDRESS_RST = 5'd0;
  localparam logic [ADDR_W-1:0] BCAST_ADDR_RST = 5'd15;
  localparam logic [7:0]        TOKEN_MARK_RST = 8'd255;
  localparam logic [7:0]        TOKEN_SIZE_RST = 8'd5;
  localparam logic [7:0]        START_CODE_RST = 8'd2;
  localparam logic [7:0]        END_CODE_RST   = 8'd3;

  // Frame position codes
  localparam logic [POS_W-1:0] POS_IDLE = 9'd0;
  localparam logic [POS_W-1:0] POS_SRC  = 9'd1;
  localparam logic [POS_W-1:0] POS_DST  = 9'd2;
  localparam logic [POS_W-1:0] POS_LEN  = 9'd3;
  localparam logic [POS_W-1:0] POS_BODY = 9'd4;

  // Bytes outside the length count: STX, src, dst, len, two trailer bytes
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd6;
  // Highest position ever held: longest frame is 255 + 6 bytes
  localparam logic [POS_W-1:0] POS_MAX        = 9'd260;

  typedef struct packed {
    logic [ADDR_W-1:0] my_address;
    logic [ADDR_W-1:0] bcast_addr;
    logic [7:0]        token_mark;
    logic [7:0]        token_size;
    logic [7:0]        start_code;
    logic [7:0]        end_code;
  } sfd_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             stuff;
    logic [7:0]       held;
    logic [7:0]       source;
    logic [7:0]       length;
    logic             fwd;
    logic             emitted;
  } sfd_state_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       route_forward;
    logic       last_byte;
    logic       end_ok;
    logic       aborted;
  } sfd_res_t;

endpackage

// ----- design/stuffed_frame_deframer_filter.sv -----
// Path: a byte accepted into the input register is processed by the step into
//   the result register, which drives the out_ ports.
// Throughput: one byte per cycle, set by the single step from input register
//   to result register; stalls only while the result register is held.
// Reset: rst_n synchronous, active low; clears frame state, both stage valids
//   and loads the register reset values (STX 2, ETX 3, token mark 255, ...).
module stuffed_frame_deframer_filter #(
  parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0] paddr,
  input  logic [sfd_pkg::PDATA_W-1:0] pwdata,
  output logic [sfd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // received bytes
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  // frame bytes
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_frame_byte,
  output logic                        out_route_forward,
  output logic                        out_last_byte,
  output logic                        out_end_ok,
  output logic                        out_aborted
);
  import sfd_pkg::*;

  sfd_cfg_t   cfg;
  sfd_state_t st_r, st_nxt;
  sfd_res_t   res, out_res_r;
  logic       emit;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  // result register
  logic       out_valid_r;
  // step fires when the input register holds a byte and the result slot is free or drains
  logic       adv;

  assign pready = 1'b1;

  sfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sfd_step #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_step (
    .cfg     (cfg),
    .st      (st_r),
    .rx_byte (in_byte_r),
    .st_nxt  (st_nxt),
    .emit    (emit),
    .res     (res)
  );

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  // input side keeps moving while a finished result waits, as long as the
  // input register is empty or drains this cycle
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame state: control fields reset, payload bytes cleared as well to
  // match the defined startup route/held values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_res_r.frame_byte;
  assign out_route_forward = out_res_r.route_forward;
  assign out_last_byte     = out_res_r.last_byte;
  assign out_end_ok        = out_res_r.end_ok;
  assign out_aborted       = out_res_r.aborted;

`ifndef SYNTHESIS
  // byte stuffing is only ever pending inside a frame
  a_stuff_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stuff |-> (st_r.pos != POS_IDLE))
    else $error("stuff pending while idle");

  // position never runs past the longest possible frame
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos <= POS_MAX)
    else $error("frame position out of range");

  // an abort transaction is a zero last byte with no end check
  a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.aborted) |->
      (out_res_r.last_byte && !out_res_r.end_ok && out_res_r.frame_byte == 8'd0))
    else $error("malformed abort transaction");

  // a step that yields nothing leaves the result register empty
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !emit) |=> !out_valid_r)
    else $error("result without a cause");
`endif

endmodule

// ----- design/sfd_cfg.sv -----
// APB-style configuration registers of the deframer.
// Depends on sfd_pkg.
module sfd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0]    paddr,
  input  logic [sfd_pkg::PDATA_W-1:0]    pwdata,
  output logic [sfd_pkg::PDATA_W-1:0]    prdata,
  output sfd_pkg::sfd_cfg_t              cfg
);
  import sfd_pkg::*;

  sfd_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_address <= MY_ADDRESS_RST;
      cfg_r.bcast_addr <= BCAST_ADDR_RST;
      cfg_r.token_mark <= TOKEN_MARK_RST;
      cfg_r.token_size <= TOKEN_SIZE_RST;
      cfg_r.start_code <= START_CODE_RST;
      cfg_r.end_code   <= END_CODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MY_ADDRESS: cfg_r.my_address <= pwdata[ADDR_W-1:0];
        REG_BCAST_ADDR: cfg_r.bcast_addr <= pwdata[ADDR_W-1:0];
        REG_TOKEN_MARK: cfg_r.token_mark <= pwdata[7:0];
        REG_TOKEN_SIZE: cfg_r.token_size <= pwdata[7:0];
        REG_START_CODE: cfg_r.start_code <= pwdata[7:0];
        REG_END_CODE:   cfg_r.end_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MY_ADDRESS: prdata = PDATA_W'(cfg_r.my_address);
      REG_BCAST_ADDR: prdata = PDATA_W'(cfg_r.bcast_addr);
      REG_TOKEN_MARK: prdata = PDATA_W'(cfg_r.token_mark);
      REG_TOKEN_SIZE: prdata = PDATA_W'(cfg_r.token_size);
      REG_START_CODE: prdata = PDATA_W'(cfg_r.start_code);
      REG_END_CODE:   prdata = PDATA_W'(cfg_r.end_code);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- design/sfd_step.sv -----
// Per-byte deframing step: next frame state and optional result item.
// Purely combinational; depends on sfd_pkg.
module sfd_step #(
  parameter int BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
  input  sfd_pkg::sfd_cfg_t   cfg,
  input  sfd_pkg::sfd_state_t st,
  input  logic [7:0]          rx_byte,
  output sfd_pkg::sfd_state_t st_nxt,
  output logic                emit,
  output sfd_pkg::sfd_res_t   res
);
  import sfd_pkg::*;

  localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
  localparam int SZ_W  = (BUF_W > POS_W + 1) ? BUF_W : POS_W + 1;

  logic             is_token;
  logic [POS_W-1:0] size_cur;
  logic [SZ_W-1:0]  size_new;
  logic             is_final;
  logic             is_start;
  logic             fwd_new;
  logic [ADDR_W-1:0] dst_addr, src_addr;

  assign is_start = (rx_byte == cfg.start_code);
  assign is_token = (st.source == cfg.token_mark);
  assign size_cur = is_token ? POS_W'(cfg.token_size)
                             : POS_W'(st.length) + FRAME_OVERHEAD;
  // size with the length byte just arriving
  assign size_new = is_token ? SZ_W'(cfg.token_size)
                             : SZ_W'(POS_W'(rx_byte) + FRAME_OVERHEAD);
  assign is_final = (st.pos >= POS_BODY) &&
                    (({1'b0, st.pos} + 10'd1) >= {1'b0, size_cur});

  assign dst_addr = rx_byte[7:8-ADDR_W];
  assign src_addr = st.source[7:8-ADDR_W];
  assign fwd_new  = !(is_token || dst_addr == cfg.my_address ||
                      src_addr == cfg.my_address ||
                      dst_addr == cfg.bcast_addr);

  always_comb begin
    st_nxt           = st;
    emit             = 1'b0;
    res.frame_byte    = st.held;
    res.route_forward = st.fwd;
    res.last_byte     = 1'b0;
    res.end_ok        = 1'b0;
    res.aborted       = 1'b0;

    if (st.pos == POS_IDLE) begin
      if (is_start) begin
        st_nxt.pos     = POS_SRC;
        st_nxt.stuff   = 1'b0;
        st_nxt.emitted = 1'b0;
      end
    end else if (st.stuff) begin
      st_nxt.stuff = 1'b0;
      if (!is_start) begin
        // restart: new frame, this byte is its source
        if (st.emitted) begin
          emit           = 1'b1;
          res.frame_byte = '0;
          res.last_byte  = 1'b1;
          res.aborted    = 1'b1;
        end
        st_nxt.emitted = 1'b0;
        st_nxt.source  = rx_byte;
        st_nxt.held    = rx_byte;
        st_nxt.pos     = POS_DST;
      end
    end else begin
      if (is_start && !is_final) st_nxt.stuff = 1'b1;
      case (st.pos)
        POS_SRC: begin
          st_nxt.source = rx_byte;
          st_nxt.held   = rx_byte;
          st_nxt.pos    = POS_DST;
        end
        POS_DST: begin
          emit              = 1'b1;
          res.route_forward = fwd_new;
          st_nxt.fwd        = fwd_new;
          st_nxt.emitted    = 1'b1;
          st_nxt.held       = rx_byte;
          st_nxt.pos        = POS_LEN;
        end
        POS_LEN: begin
          emit          = 1'b1;
          st_nxt.length = rx_byte;
          if (size_new > SZ_W'(BUFFER_BYTES)) begin
            res.frame_byte = '0;
            res.last_byte  = 1'b1;
            res.aborted    = 1'b1;
            st_nxt.pos     = POS_IDLE;
            st_nxt.stuff   = 1'b0;
            st_nxt.emitted = 1'b0;
          end else begin
            st_nxt.held = rx_byte;
            st_nxt.pos  = POS_BODY;
          end
        end
        default: begin
          emit = 1'b1;
          if (is_final) begin
            res.last_byte  = 1'b1;
            res.end_ok     = (rx_byte == cfg.end_code);
            st_nxt.pos     = POS_IDLE;
            st_nxt.stuff   = 1'b0;
            st_nxt.emitted = 1'b0;
          end else begin
            st_nxt.held = rx_byte;
            st_nxt.pos  = st.pos + 9'd1;
          end
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/stuffed_frame_deframer_filter_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for stuffed_frame_deframer_filter: directed and random
// ring traffic, a bit-exact frame predictor and a scoreboard of frame bytes.
// Depends on sfd_pkg and the deframer RTL only.
module stuffed_frame_deframer_filter_test;
  import sfd_pkg::*;

  localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
  localparam int DRAIN_CYCLES = 6;     // pipeline: input register and result register
  localparam int HOLD_CYCLES  = 300;   // long receiver back-pressure
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_frame_byte;
  logic                out_route_forward;
  logic                out_last_byte;
  logic                out_end_ok;
  logic                out_aborted;

  stuffed_frame_deframer_filter #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_route_forward(out_route_forward),
    .out_last_byte    (out_last_byte),
    .out_end_ok       (out_end_ok),
    .out_aborted      (out_aborted)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  int       errors;
  int       rx_sent;        // bytes offered that take part in a frame
  bit       steady;         // no idling on either side while set
  int       hold_left;      // receiver back-pressure, counted down below

  // Shadow of the register file and the deframer's own frame state
  sfd_cfg_t regs;
  logic [POS_W-1:0] frm_pos;
  bit               frm_stuff;
  logic [7:0]       frm_held;
  logic [7:0]       frm_src;
  logic [7:0]       frm_len;
  bit               frm_fwd;
  bit               frm_emitted;

  // Frame bytes the block owes us, oldest first
  sfd_res_t frame_bytes_due[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_predictor();
    regs.my_address = MY_ADDRESS_RST;
    regs.bcast_addr = BCAST_ADDR_RST;
    regs.token_mark = TOKEN_MARK_RST;
    regs.token_size = TOKEN_SIZE_RST;
    regs.start_code = START_CODE_RST;
    regs.end_code   = END_CODE_RST;
    frm_pos     = POS_IDLE;
    frm_stuff   = 1'b0;
    frm_held    = '0;
    frm_src     = '0;
    frm_len     = '0;
    frm_fwd     = 1'b0;
    frm_emitted = 1'b0;
  endfunction

  function automatic void go_idle();
    frm_pos     = POS_IDLE;
    frm_stuff   = 1'b0;
    frm_emitted = 1'b0;
  endfunction

  // Tokens have a fixed size, everything else is length + overhead
  function automatic int frame_length();
    if (frm_src == regs.token_mark) return int'(regs.token_size);
    return int'(frm_len) + int'(FRAME_OVERHEAD);
  endfunction

  // Never before the first body byte, so short tokens end at the fifth byte
  function automatic bit at_last_byte();
    return frm_pos >= POS_BODY && int'(frm_pos) + 1 >= frame_length();
  endfunction

  function automatic void expect_frame_byte(logic [7:0] b, bit last, bit ok, bit ab);
    sfd_res_t r;
    r.frame_byte    = b;
    r.route_forward = frm_fwd;
    r.last_byte     = last;
    r.end_ok        = ok;
    r.aborted       = ab;
    frame_bytes_due.push_back(r);
  endfunction

  // A data byte at the current position; from the destination on, emits the byte held from before or an abort
  function automatic void store_frame_byte(logic [7:0] b);
    case (frm_pos)
      POS_SRC: begin
        frm_src  = b;
        frm_held = b;
        frm_pos  = POS_DST;
      end
      POS_DST: begin
        // local delivery: token, to/from this station, or broadcast
        frm_fwd = !(frm_src == regs.token_mark || b[7:3] == regs.my_address ||
                    frm_src[7:3] == regs.my_address ||
                    b[7:3] == regs.bcast_addr);
        expect_frame_byte(frm_held, 1'b0, 1'b0, 1'b0);
        frm_emitted = 1'b1;
        frm_held    = b;
        frm_pos     = POS_LEN;
      end
      POS_LEN: begin
        frm_len = b;
        if (frame_length() > BUFFER_BYTES) begin
          // too big for the buffer: abort marker replaces the destination
          expect_frame_byte(8'h00, 1'b1, 1'b0, 1'b1);
          go_idle();
        end else begin
          expect_frame_byte(frm_held, 1'b0, 1'b0, 1'b0);
          frm_held = b;
          frm_pos  = POS_BODY;
        end
      end
      default: begin
        if (at_last_byte()) begin
          expect_frame_byte(frm_held, 1'b1, b == regs.end_code, 1'b0);
          go_idle();
        end else begin
          expect_frame_byte(frm_held, 1'b0, 1'b0, 1'b0);
          frm_held = b;
          frm_pos  = frm_pos + 1'b1;
        end
      end
    endcase
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    if (frm_pos == POS_IDLE) begin
      // line noise is dropped until a start code shows up
      if (b == regs.start_code) begin
        frm_pos     = POS_SRC;
        frm_stuff   = 1'b0;
        frm_emitted = 1'b0;
      end
      return;
    end
    if (frm_stuff) begin
      frm_stuff = 1'b0;
      // doubled start code: the first copy was already kept as data
      if (b == regs.start_code) return;
      // start code + other byte: restart, flag whatever went out already
      if (frm_emitted) expect_frame_byte(8'h00, 1'b1, 1'b0, 1'b1);
      frm_pos     = POS_SRC;
      frm_emitted = 1'b0;
      store_frame_byte(b);
      return;
    end
    // the last byte of a frame is never the first half of a stuffed pair
    if (b == regs.start_code && !at_last_byte()) frm_stuff = 1'b1;
    store_frame_byte(b);
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard and monitor, both sampled at the rising edge
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want,
                                        logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_frame_byte();
    sfd_res_t want;
    if (frame_bytes_due.size() == 0) begin
      $error("frame_byte: expected nothing, got %0h", out_frame_byte);
      errors++;
      return;
    end
    want = frame_bytes_due.pop_front();
    compare_field("frame_byte",    32'(want.frame_byte),    32'(out_frame_byte));
    compare_field("route_forward", 32'(want.route_forward), 32'(out_route_forward));
    compare_field("last_byte",     32'(want.last_byte),     32'(out_last_byte));
    compare_field("end_ok",        32'(want.end_ok),        32'(out_end_ok));
    compare_field("aborted",       32'(want.aborted),       32'(out_aborted));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_frame_byte();
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
    end
  end

  // Watchdog: any transaction on any port restarts the count
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(99) >= 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  // One received byte; valid may drop for random gaps before it
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    rx_sent++;
  endtask

  // Data byte inside a frame: a start code goes out twice
  task automatic send_stuffed(input logic [7:0] b);
    send_byte(b);
    if (b == regs.start_code) send_byte(b);
  endtask

  // Bytes outside any frame; the block ignores them
  task automatic send_idle_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (b == regs.start_code) b = ~b;
      send_byte(b);
    end
    rx_sent -= count;
  endtask

  // Whole frame with random payload. cut >= 0 sends that many body bytes,
  // then a start code, then the full frame again (restart mid-frame).
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] len, input logic [7:0] fin,
                            input int cut);
    logic [7:0] body[$];
    logic [7:0] b;
    int         last_pos;
    bit         is_token;
    bit         too_big;
    is_token = (src == regs.token_mark);
    if (is_token)
      last_pos = (regs.token_size < 5) ? 4 : int'(regs.token_size) - 1;
    else
      last_pos = int'(len) + 5;
    too_big = !is_token && last_pos + 1 > BUFFER_BYTES;
    body = '{src, dst, len};
    if (!too_big) begin
      repeat (last_pos - 4) begin
        b = 8'($urandom);
        body.push_back(b);
      end
    end
    if (too_big || src == regs.start_code) cut = -1;
    if (cut >= body.size()) cut = body.size() - 1;
    send_byte(regs.start_code);
    if (cut >= 0) begin
      for (int i = 0; i < cut; i++) send_stuffed(body[i]);
      send_byte(regs.start_code);
    end
    foreach (body[i]) send_stuffed(body[i]);
    if (!too_big) send_byte(fin);
  endtask

  // Drop valid and wait for every owed frame byte plus pipeline drain
  task automatic wait_drained();
    in_valid = 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    kept = value & ((idx == REG_MY_ADDRESS || idx == REG_BCAST_ADDR) ?
                    32'h1F : 32'hFF);
    case (idx)
      REG_MY_ADDRESS: regs.my_address = kept[ADDR_W-1:0];
      REG_BCAST_ADDR: regs.bcast_addr = kept[ADDR_W-1:0];
      REG_TOKEN_MARK: regs.token_mark = kept[7:0];
      REG_TOKEN_SIZE: regs.token_size = kept[7:0];
      REG_START_CODE: regs.start_code = kept[7:0];
      REG_END_CODE:   regs.end_code   = kept[7:0];
      default: ;
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    compare_field("prdata", kept, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_settings(input logic [4:0] my, input logic [4:0] bcast,
                                input logic [7:0] mark, input logic [7:0] tsize,
                                input logic [7:0] stx, input logic [7:0] etx);
    wait_drained();
    write_register(REG_MY_ADDRESS, 32'(my));
    write_register(REG_BCAST_ADDR, 32'(bcast));
    write_register(REG_TOKEN_MARK, 32'(mark));
    write_register(REG_TOKEN_SIZE, 32'(tsize));
    write_register(REG_START_CODE, 32'(stx));
    write_register(REG_END_CODE,   32'(etx));
  endtask

  task automatic restore_defaults();
    apply_settings(MY_ADDRESS_RST, BCAST_ADDR_RST, TOKEN_MARK_RST,
                   TOKEN_SIZE_RST, START_CODE_RST, END_CODE_RST);
  endtask

  // Address byte biased toward this station and broadcast, so both routes occur
  function automatic logic [7:0] pick_station_byte();
    logic [2:0] low;
    logic [7:0] any;
    int         pick;
    low  = 3'($urandom);
    any  = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) return {regs.my_address, low};
    if (pick < 40) return {regs.bcast_addr, low};
    return any;
  endfunction

  // Mostly well-formed frames; some restarts, overflows, bad ends and noise
  task automatic send_random_sequence();
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] len;
    logic [7:0] fin;
    int         kind;
    int         pick;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_idle_noise(int'($urandom_range(1, 4)));
      return;
    end
    src = pick_station_byte();
    dst = pick_station_byte();
    if (regs.token_size <= 16 && $urandom_range(99) < 15) src = regs.token_mark;
    pick = $urandom_range(99);
    if (pick < 75)      len = 8'($urandom_range(0, 8));
    else if (pick < 92) len = 8'($urandom_range(9, 30));
    else                len = 8'($urandom_range(251, 255));
    fin = 8'($urandom);
    if ($urandom_range(99) < 85) fin = regs.end_code;
    send_frame(src, dst, len, fin, (kind < 20) ? int'($urandom_range(0, 5)) : -1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // All-ones write checks masking on read-back, then defaults again
  task automatic test_register_access();
    for (int i = REG_MY_ADDRESS; i <= REG_END_CODE; i++)
      write_register(i[2:0], 32'hFFFF_FFFF);
    restore_defaults();
  endtask

  task automatic test_token_frames();
    send_byte(8'h00);                                  // idle noise, extremes
    send_byte(8'hFF);
    send_frame(regs.token_mark, 8'h08, 8'h00, regs.end_code, -1);
    send_frame(regs.token_mark, 8'hFF, 8'hFF, 8'h00, -1);   // bad end byte
    // token size under five still ends on the fifth byte
    apply_settings(MY_ADDRESS_RST, BCAST_ADDR_RST, TOKEN_MARK_RST, 8'd3,
                   START_CODE_RST, END_CODE_RST);
    send_frame(regs.token_mark, 8'h30, 8'h07, regs.end_code, -1);
    restore_defaults();
  endtask

  task automatic test_stuffing_and_end_check();
    // stuffed destination and length, start code as the final byte
    send_frame(8'h80, regs.start_code, regs.start_code, regs.start_code, -1);
    // broadcast, empty payload
    send_frame(8'h00, {BCAST_ADDR_RST, 3'b000}, 8'h00, regs.end_code, -1);
    // foreign source and destination: forwarded
    send_frame(8'hC8, 8'h50, 8'h01, regs.end_code, -1);
  endtask

  task automatic test_restart_abort();
    send_frame(8'h10, 8'h20, 8'h01, regs.end_code, 2);   // bytes already out
    send_frame(8'h10, 8'h20, 8'h00, regs.end_code, 0);   // nothing out yet
  endtask

  task automatic test_overflow_abort();
    send_frame(8'h48, 8'h90, 8'd251, regs.end_code, -1);
    send_idle_noise(2);
    send_frame(8'h48, 8'h90, 8'd255, regs.end_code, -1);
    // largest frame that fits the buffer, sent without gaps
    steady = 1'b1;
    send_frame(8'h48, 8'h90, 8'd250, regs.end_code, -1);
    steady = 1'b0;
  endtask

  // Receiver stalls long enough for the input to back up, then the sender
  // waits for every outstanding frame byte
  task automatic test_backpressure();
    wait_drained();
    hold_left = HOLD_CYCLES;
    repeat (4) send_frame(pick_station_byte(), pick_station_byte(),
                          8'($urandom_range(2, 8)), regs.end_code, -1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int budget;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: restore_defaults();
        1: apply_settings(5'd31, 5'd0, 8'h00, 8'd255, 8'hFF, 8'h00);
        2: apply_settings(5'd0, 5'd31, 8'hFF, 8'd5, 8'h00, 8'hFF);
        3: apply_settings(5'($urandom), 5'($urandom), 8'($urandom), 8'd3,
                          8'($urandom), 8'($urandom));
        default: apply_settings(5'($urandom), 5'($urandom), 8'($urandom),
                                8'($urandom_range(5, 12)), 8'($urandom),
                                8'($urandom));
      endcase
      steady = (phase == 0);       // one long stretch with no idling at all
      budget = rx_sent + 50;
      while (rx_sent < budget) send_random_sequence();
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors     = 0;
    rx_sent    = 0;
    steady     = 1'b0;
    hold_left  = 0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_n      = 1'b0;
    reset_predictor();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_token_frames();
    test_stuffing_and_end_check();
    test_restart_abort();
    test_overflow_abort();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0 && frame_bytes_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
